/* hdl/tcw_pkg.sv */
// Package for the text console writer: geometry, codes and payload types.
// Shared by every module of the block; depends on nothing.
package tcw_pkg;

    localparam int COLS    = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int IDX_W   = 11;
    localparam int PADDR_W = 4;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [7:0]  BLANK_CHAR = 8'h20;
    localparam logic [7:0]  PLAIN_ATTR = 8'h07;
    localparam logic [15:0] RESET_CELL = 16'h0720;
    localparam logic [3:0]  TAB_MAX    = 4'd8;
    localparam logic [7:0]  CHAR_NL    = 8'h0A;
    localparam logic [7:0]  CHAR_BS    = 8'h08;
    localparam logic [7:0]  CHAR_TAB   = 8'h09;

    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [1:0] REG_TEXT_ATTR   = 2'd0;
    localparam logic [1:0] REG_SERIAL_ECHO = 2'd1;
    localparam logic [1:0] REG_TAB_WIDTH   = 2'd2;

    localparam logic [3:0] TAB_WIDTH_RESET = 4'd4;

    typedef enum logic [2:0] {
        OP_CHAR,
        OP_NEWLINE,
        OP_BKSP,
        OP_TAB,
        OP_CLEAR,
        OP_READ,
        OP_NOP
    } op_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_ECHO,
        ST_BS_WR,
        ST_TAB,
        ST_SETTLE,
        ST_SCROLL,
        ST_FILL,
        ST_READ,
        ST_FINAL
    } bstate_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  char_code;
        logic        plain_mode;
        logic [10:0] cell_index;
    } req_t;

    typedef struct packed {
        logic        is_echo;
        logic [7:0]  echo_byte;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [10:0] cursor_index;
        logic        cursor_written;
        logic [15:0] cell_word;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [7:0] text_attr;
        logic       serial_echo;
        logic [3:0] tab_width;
    } cfg_t;

    typedef struct packed {
        op_t              op;
        logic [7:0]       ch;
        logic [7:0]       attr;
        logic [7:0]       fill_attr;
        logic             echo;
        logic [3:0]       tab_cnt;
        logic [1:0]       tab_reps;
        logic             idx_ok;
        logic [IDX_W-1:0] cell_index;
    } cmd_t;

endpackage

/* hdl/tcw_regs.sv */
// Configuration registers behind the APB-style port.
// Depends on tcw_pkg.
module tcw_regs
    import tcw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.text_attr   <= PLAIN_ATTR;
            cfg_reg.serial_echo <= 1'b0;
            cfg_reg.tab_width   <= TAB_WIDTH_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_TEXT_ATTR:   cfg_reg.text_attr   <= pwdata[7:0];
                REG_SERIAL_ECHO: cfg_reg.serial_echo <= pwdata[0];
                REG_TAB_WIDTH:   cfg_reg.tab_width   <= pwdata[3:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_TEXT_ATTR:   prdata = {24'd0, cfg_reg.text_attr};
            REG_SERIAL_ECHO: prdata = {31'd0, cfg_reg.serial_echo};
            REG_TAB_WIDTH:   prdata = {28'd0, cfg_reg.tab_width};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

/* hdl/tcw_front.sv */
// Front end: accepts requests and turns them into console commands.
// Depends on tcw_pkg; feeds tcw_fifo.
module tcw_front
    import tcw_pkg::*;
(
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    input  cfg_t cfg,
    input  logic init_done,
    input  logic q_full,
    output logic q_push,
    output cmd_t q_data
);

    logic [3:0] tab_sat;

    assign req_ready = init_done && !q_full;
    assign q_push    = req_valid && req_ready;
    assign tab_sat   = (cfg.tab_width > TAB_MAX) ? TAB_MAX : cfg.tab_width;

    always_comb
    begin
        q_data            = '0;
        q_data.ch         = req.char_code;
        q_data.attr       = req.plain_mode ? PLAIN_ATTR : cfg.text_attr;
        q_data.fill_attr  = cfg.text_attr;
        q_data.echo       = req.plain_mode || cfg.serial_echo;
        q_data.tab_cnt    = tab_sat;
        q_data.tab_reps   = cfg.serial_echo ? (req.plain_mode ? 2'd1 : 2'd2) : 2'd0;
        q_data.idx_ok     = (req.cell_index < IDX_W'(CELLS));
        q_data.cell_index = req.cell_index;
        case (req.req_type)
            REQ_PUT:
            begin
                case (req.char_code)
                    CHAR_NL:  q_data.op = OP_NEWLINE;
                    CHAR_BS:  q_data.op = OP_BKSP;
                    CHAR_TAB: q_data.op = OP_TAB;
                    default:  q_data.op = OP_CHAR;
                endcase
            end
            REQ_CLEAR: q_data.op = OP_CLEAR;
            REQ_READ:  q_data.op = OP_READ;
            default:   q_data.op = OP_NOP;
        endcase
    end

endmodule

/* hdl/tcw_fifo.sv */
// Short command queue between the front end and the console engine.
// Depends on tcw_pkg.
module tcw_fifo
    import tcw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_data
);

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* hdl/tcw_back.sv */
// Console engine: cell store, cursor, scroll and clear sweeps, result register.
// Depends on tcw_pkg; takes commands from tcw_fifo.
module tcw_back
    import tcw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    input  cmd_t q_data,
    output logic q_pop,
    output logic init_done,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    logic [15:0] mem [CELLS];

    bstate_t           state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [3:0]        tab_left_reg, tab_left_next;
    logic [1:0]        echo_cnt_reg, echo_cnt_next;
    logic [7:0]        echo_byte_reg, echo_byte_next;
    logic [ADDR_W-1:0] fill_addr_reg, fill_addr_next;
    logic [ADDR_W-1:0] sc_reg, sc_next;
    logic              cp_valid_reg, cp_valid_next;
    logic [ADDR_W-1:0] cp_addr_reg, cp_addr_next;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_reg, out_next;
    logic [15:0]       rdata_reg;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [15:0]       wdata;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] cur_pos;
    logic              can_emit;
    logic              emit;
    rsp_t              emit_data;
    logic              wrap;
    logic [ROW_W-1:0]  row_w;
    logic              more_tabs;

    assign cur_pos   = ADDR_W'(32'(row_reg) * COLS + 32'(col_reg));
    assign can_emit  = !out_valid_reg || rsp_ready;
    assign init_done = (state_reg != ST_INIT);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign wrap      = (col_reg >= COL_W'(COLS));
    assign row_w     = wrap ? row_reg + 1'b1 : row_reg;
    assign more_tabs = (cmd_reg.op == OP_TAB) && (tab_left_reg != 4'd0);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
        cmd_reg   <= cmd_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            row_reg       <= '0;
            col_reg       <= '0;
            tab_left_reg  <= '0;
            echo_cnt_reg  <= '0;
            echo_byte_reg <= '0;
            fill_addr_reg <= '0;
            sc_reg        <= '0;
            cp_valid_reg  <= 1'b0;
            cp_addr_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            tab_left_reg  <= tab_left_next;
            echo_cnt_reg  <= echo_cnt_next;
            echo_byte_reg <= echo_byte_next;
            fill_addr_reg <= fill_addr_next;
            sc_reg        <= sc_next;
            cp_valid_reg  <= cp_valid_next;
            cp_addr_reg   <= cp_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        tab_left_next  = tab_left_reg;
        echo_cnt_next  = echo_cnt_reg;
        echo_byte_next = echo_byte_reg;
        fill_addr_next = fill_addr_reg;
        sc_next        = sc_reg;
        cp_valid_next  = cp_valid_reg;
        cp_addr_next   = cp_addr_reg;
        we             = 1'b0;
        waddr          = cur_pos;
        wdata          = {cmd_reg.fill_attr, BLANK_CHAR};
        raddr          = cmd_reg.idx_ok ? ADDR_W'(cmd_reg.cell_index) : '0;
        q_pop          = 1'b0;
        emit           = 1'b0;
        emit_data      = '0;

        case (state_reg)
            ST_INIT:
            begin
                we             = 1'b1;
                waddr          = fill_addr_reg;
                wdata          = RESET_CELL;
                fill_addr_next = fill_addr_reg + 1'b1;
                if (fill_addr_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_data;
                    case (q_data.op)
                        OP_CHAR:
                        begin
                            we             = 1'b1;
                            wdata          = {q_data.attr, q_data.ch};
                            col_next       = col_reg + 1'b1;
                            echo_cnt_next  = {1'b0, q_data.echo};
                            echo_byte_next = q_data.ch;
                            state_next     = ST_ECHO;
                        end
                        OP_NEWLINE:
                        begin
                            col_next       = '0;
                            row_next       = row_reg + 1'b1;
                            echo_cnt_next  = {1'b0, q_data.echo};
                            echo_byte_next = q_data.ch;
                            state_next     = ST_ECHO;
                        end
                        OP_BKSP:
                        begin
                            if (col_reg > COL_W'(2))
                            begin
                                col_next   = col_reg - 1'b1;
                                state_next = ST_BS_WR;
                            end
                            else
                            begin
                                state_next = ST_FINAL;
                            end
                        end
                        OP_TAB:
                        begin
                            tab_left_next = q_data.tab_cnt;
                            state_next    = ST_SETTLE;
                        end
                        OP_CLEAR:
                        begin
                            row_next       = '0;
                            col_next       = '0;
                            fill_addr_next = '0;
                            state_next     = ST_FILL;
                        end
                        OP_READ:
                        begin
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_FINAL;
                        end
                    endcase
                end
            end
            ST_BS_WR:
            begin
                we             = 1'b1;
                wdata          = {cmd_reg.attr, BLANK_CHAR};
                echo_cnt_next  = {1'b0, cmd_reg.echo};
                echo_byte_next = cmd_reg.ch;
                state_next     = ST_ECHO;
            end
            ST_TAB:
            begin
                we             = 1'b1;
                wdata          = {cmd_reg.fill_attr, BLANK_CHAR};
                col_next       = col_reg + 1'b1;
                tab_left_next  = tab_left_reg - 1'b1;
                echo_cnt_next  = cmd_reg.tab_reps;
                echo_byte_next = BLANK_CHAR;
                state_next     = ST_ECHO;
            end
            ST_ECHO:
            begin
                if (echo_cnt_reg == 2'd0)
                begin
                    state_next = ST_SETTLE;
                end
                else if (can_emit)
                begin
                    emit                = 1'b1;
                    emit_data.is_echo   = 1'b1;
                    emit_data.echo_byte = echo_byte_reg;
                    echo_cnt_next       = echo_cnt_reg - 1'b1;
                end
            end
            ST_SETTLE:
            begin
                if (wrap)
                begin
                    col_next = '0;
                end
                if (row_w >= ROW_W'(ROWS))
                begin
                    row_next      = ROW_W'(ROWS - 1);
                    sc_next       = '0;
                    cp_valid_next = 1'b0;
                    state_next    = ST_SCROLL;
                end
                else
                begin
                    row_next   = row_w;
                    state_next = more_tabs ? ST_TAB : ST_FINAL;
                end
            end
            ST_SCROLL:
            begin
                if (sc_reg < ADDR_W'(CELLS - COLS))
                begin
                    raddr         = sc_reg + ADDR_W'(COLS);
                    cp_valid_next = 1'b1;
                    cp_addr_next  = sc_reg;
                    sc_next       = sc_reg + 1'b1;
                end
                else
                begin
                    cp_valid_next  = 1'b0;
                    fill_addr_next = ADDR_W'(CELLS - COLS);
                    state_next     = ST_FILL;
                end
                if (cp_valid_reg)
                begin
                    we    = 1'b1;
                    waddr = cp_addr_reg;
                    wdata = rdata_reg;
                end
            end
            ST_FILL:
            begin
                we             = 1'b1;
                waddr          = fill_addr_reg;
                fill_addr_next = fill_addr_reg + 1'b1;
                if (fill_addr_reg == ADDR_W'(CELLS - 1))
                begin
                    if (cmd_reg.op == OP_CLEAR)
                    begin
                        state_next = ST_FINAL;
                    end
                    else
                    begin
                        state_next = more_tabs ? ST_TAB : ST_FINAL;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                if (can_emit)
                begin
                    emit                   = 1'b1;
                    emit_data.cursor_row   = row_reg;
                    emit_data.cursor_col   = col_reg;
                    emit_data.cursor_index = IDX_W'(cur_pos);
                    emit_data.cursor_written = (cmd_reg.op == OP_CHAR)
                                            || (cmd_reg.op == OP_NEWLINE)
                                            || (cmd_reg.op == OP_BKSP)
                                            || (cmd_reg.op == OP_TAB);
                    emit_data.cell_word = ((cmd_reg.op == OP_READ) && cmd_reg.idx_ok)
                                        ? rdata_reg : 16'd0;
                    emit_data.last = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_next       = emit_data;
        end
        else
        begin
            out_valid_next = out_valid_reg && !rsp_ready;
            out_next       = out_reg;
        end
    end

endmodule

/* hdl/text_console_writer.sv */
// Top level of the text console writer: registers, front end, queue, engine.
// Depends on tcw_pkg, tcw_regs, tcw_front, tcw_fifo and tcw_back.
//
// An 80x25 text console with a 2000-cell store, written through a
// valid/ready request channel; results leave through a registered
// valid/ready channel, and a four-entry command queue lets requests be
// taken while the engine works. After reset the store is swept to blank
// 0x0720, one cell a cycle, and no request is taken until the sweep is
// done (configuration writes are taken at once). The engine does one
// request at a time. A character, newline or backspace sends its echo
// byte when echo is on; a backspace at column 2 or less only sends its
// cursor result. A tab writes its spaces one at a time, with echoes.
// A scroll goes through the single-port-write cell store one cell a
// cycle, copying each cell one row up, and blanks the 80 cells of the
// bottom row; a clear blanks every cell. A result that waits on
// rsp_ready can hold the engine.
module text_console_writer
    import tcw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  req_t               req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rsp_t               rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cfg_t cfg;
    logic init_done;
    logic q_full;
    logic q_push;
    cmd_t q_in;
    logic q_pop;
    logic q_valid;
    cmd_t q_head;

    tcw_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tcw_front u_front (
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cfg       (cfg),
        .init_done (init_done),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    tcw_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    tcw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_head),
        .q_pop     (q_pop),
        .init_done (init_done),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

/* bench/tb_text_console_writer.sv */
// Self-checking testbench for the text console writer: requests over valid/ready, APB setup.
// A shadow console predicts every result; depends on tcw_pkg and text_console_writer.
module tb_text_console_writer;
    timeunit 1ns;
    timeprecision 1ps;
    import tcw_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    // Slowest run: ~240 requests, each scrolling, with up to 17 stalled results.
    localparam int LIMIT       = 3_000_000;
    localparam int DRAIN_PAUSE = 50;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    req_t               req       = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    rsp_t               rsp;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [31:0]        pwdata    = '0;
    logic [31:0]        prdata;
    logic               pready;

    logic [15:0] shadow_cells [CELLS];
    int unsigned crow;
    int unsigned ccol;
    cfg_t        cfg;
    rsp_t        expected_rsps [$];

    int errors       = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int scrolls      = 0;
    int clears       = 0;
    int settings     = 0;
    int cycle_count  = 0;
    int idle_pct     = 33;

    text_console_writer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
        cycle_count++;

    initial
    begin
        wait (cycle_count >= LIMIT);
        $display("Timeout after %0d cycles, %0d results still pending",
                 LIMIT, expected_rsps.size());
        $display("CHECKS FAILED");
        $finish;
    end

    always @(negedge clk)
        rsp_ready = ($urandom_range(99) >= idle_pct);

    // ---------------- shadow console ----------------

    function automatic void queue_echo(logic [7:0] b);
        rsp_t r;
        r = '0;
        r.is_echo   = 1'b1;
        r.echo_byte = b;
        expected_rsps.push_back(r);
    endfunction

    function automatic void queue_cursor(logic wr, logic [15:0] word);
        rsp_t        r;
        int unsigned pos;
        pos = crow * COLS + ccol;
        r = '0;
        r.cursor_row     = crow[4:0];
        r.cursor_col     = ccol[6:0];
        r.cursor_index   = pos[10:0];
        r.cursor_written = wr;
        r.cell_word      = word;
        r.last           = 1'b1;
        expected_rsps.push_back(r);
    endfunction

    function automatic void write_cell(logic [7:0] ch, logic [7:0] attr);
        int unsigned pos;
        pos = crow * COLS + ccol;
        if (pos < CELLS)
            shadow_cells[pos] = {attr, ch};
    endfunction

    function automatic void scroll_up();
        for (int i = 0; i < CELLS - COLS; i++)
            shadow_cells[i] = shadow_cells[i + COLS];
        for (int i = CELLS - COLS; i < CELLS; i++)
            shadow_cells[i] = {cfg.text_attr, BLANK_CHAR};
        scrolls++;
    endfunction

    function automatic void settle_cursor();
        if (ccol >= COLS)
        begin
            ccol = 0;
            crow++;
        end
        if (crow >= ROWS)
        begin
            scroll_up();
            crow = ROWS - 1;
        end
    endfunction

    function automatic void predict(req_t r);
        logic        echo;
        logic [7:0]  attr;
        int unsigned spaces;
        echo = r.plain_mode | cfg.serial_echo;
        attr = r.plain_mode ? PLAIN_ATTR : cfg.text_attr;
        case (r.req_type)
            REQ_PUT:
            begin
                if (r.char_code == CHAR_NL)
                begin
                    ccol = 0;
                    crow++;
                    if (echo)
                        queue_echo(r.char_code);
                end
                else if (r.char_code == CHAR_BS)
                begin
                    if (ccol > 2)
                    begin
                        ccol--;
                        write_cell(BLANK_CHAR, attr);
                        if (echo)
                            queue_echo(r.char_code);
                    end
                end
                else if (r.char_code == CHAR_TAB)
                begin
                    spaces = 32'((cfg.tab_width > TAB_MAX) ? TAB_MAX : cfg.tab_width);
                    for (int k = 0; k < spaces; k++)
                    begin
                        // tab spaces always take the register attribute
                        write_cell(BLANK_CHAR, cfg.text_attr);
                        ccol++;
                        settle_cursor();
                        if (cfg.serial_echo)
                        begin
                            queue_echo(BLANK_CHAR);
                            if (!r.plain_mode)
                                queue_echo(BLANK_CHAR);
                        end
                    end
                end
                else
                begin
                    write_cell(r.char_code, attr);
                    ccol++;
                    if (echo)
                        queue_echo(r.char_code);
                end
                settle_cursor();
                queue_cursor(1'b1, 16'h0);
            end
            REQ_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    shadow_cells[i] = {cfg.text_attr, BLANK_CHAR};
                crow = 0;
                ccol = 0;
                clears++;
                queue_cursor(1'b0, 16'h0);
            end
            REQ_READ:
                queue_cursor(1'b0, (r.cell_index < CELLS) ? shadow_cells[r.cell_index] : 16'h0);
            default:
                queue_cursor(1'b0, 16'h0);
        endcase
    endfunction

    // ---------------- result checking ----------------

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            if (errors <= 60)
                $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : rsp_monitor
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            results_seen++;
            if (expected_rsps.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transaction: expected none, actual %h", $time, rsp);
            end
            else
            begin
                want = expected_rsps.pop_front();
                check_field("is_echo", 16'(want.is_echo), 16'(rsp.is_echo));
                check_field("echo_byte", 16'(want.echo_byte), 16'(rsp.echo_byte));
                check_field("cursor_row", 16'(want.cursor_row), 16'(rsp.cursor_row));
                check_field("cursor_col", 16'(want.cursor_col), 16'(rsp.cursor_col));
                check_field("cursor_index", 16'(want.cursor_index),
                            16'(rsp.cursor_index));
                check_field("cursor_written", 16'(want.cursor_written),
                            16'(rsp.cursor_written));
                check_field("cell_word", want.cell_word, rsp.cell_word);
                check_field("last", 16'(want.last), 16'(rsp.last));
            end
        end
    end

    // ---------------- drivers ----------------

    task automatic send_req(req_t r);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        req       = r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predict(r);
        items_sent++;
    endtask

    task automatic wait_results_done();
        @(negedge clk);
        req_valid = 1'b0;
        while (expected_rsps.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        case (idx)
            REG_TEXT_ATTR:   cfg.text_attr   = value[7:0];
            REG_SERIAL_ECHO: cfg.serial_echo = value[0];
            REG_TAB_WIDTH:   cfg.tab_width   = value[3:0];
            default:         ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apply_config(logic [7:0] attr, logic echo, logic [3:0] tabw);
        wait_results_done();
        write_reg(REG_TEXT_ATTR, {24'h0, attr});
        write_reg(REG_SERIAL_ECHO, {31'h0, echo});
        write_reg(REG_TAB_WIDTH, {28'h0, tabw});
        settings++;
    endtask

    // ---------------- request builders ----------------

    function automatic req_t put_item(logic [7:0] ch, logic plain);
        req_t r;
        r.req_type   = REQ_PUT;
        r.char_code  = ch;
        r.plain_mode = plain;
        r.cell_index = 11'($urandom);
        return r;
    endfunction

    function automatic req_t read_item(logic [10:0] idx);
        req_t r;
        r.req_type   = REQ_READ;
        r.char_code  = 8'($urandom);
        r.plain_mode = 1'($urandom);
        r.cell_index = idx;
        return r;
    endfunction

    function automatic req_t other_item(logic [1:0] kind);
        req_t r;
        r.req_type   = kind;
        r.char_code  = 8'($urandom);
        r.plain_mode = 1'($urandom);
        r.cell_index = 11'($urandom);
        return r;
    endfunction

    function automatic logic [7:0] printable();
        return 8'($urandom_range(126, 33));
    endfunction

    function automatic req_t random_put(int nl_pct);
        int unsigned pick;
        logic [7:0]  ch;
        pick = $urandom_range(99);
        if (pick < nl_pct)
            ch = CHAR_NL;
        else if (pick < nl_pct + 10)
            ch = CHAR_TAB;
        else if (pick < nl_pct + 18)
            ch = CHAR_BS;
        else if (pick < nl_pct + 30)
            ch = 8'($urandom);
        else
            ch = printable();
        return put_item(ch, $urandom_range(3) == 0);
    endfunction

    function automatic req_t random_item(int nl_pct);
        int unsigned pick;
        int unsigned near;
        pick = $urandom_range(99);
        near = crow * COLS + ccol;
        if (near > 3)
            near = near - $urandom_range(3, 1);
        if (pick < 74)
            return random_put(nl_pct);
        if (pick < 86)
            return read_item(near[10:0]);
        if (pick < 94)
            return read_item(11'($urandom));
        if (pick < 97)
            return other_item(REQ_UNUSED);
        return other_item(REQ_CLEAR);
    endfunction

    // ---------------- tests ----------------

    task automatic test_reset_contents();
        send_req(read_item(11'd0));
        send_req(read_item(11'(CELLS - 1)));
        send_req(read_item(11'(CELLS)));
        send_req(read_item(11'h7FF));
        send_req(read_item(11'($urandom_range(CELLS - 1))));
        send_req(other_item(REQ_UNUSED));
    endtask

    task automatic test_put_basics();
        send_req(put_item(8'h00, 1'b0));
        send_req(put_item(8'hFF, 1'b0));
        send_req(put_item(8'h41, 1'b1));
        send_req(put_item(CHAR_BS, 1'b0));   // column 3: blanks cell 2
        send_req(put_item(CHAR_BS, 1'b1));   // column 2: no effect
        send_req(put_item(CHAR_TAB, 1'b0));
        send_req(put_item(CHAR_TAB, 1'b1));
        send_req(put_item(CHAR_NL, 1'b0));
        send_req(put_item(CHAR_NL, 1'b1));
        send_req(put_item(8'h7F, 1'b1));
        for (int i = 0; i < 4; i++)
            send_req(read_item(11'(i)));
        send_req(read_item(11'd7));
    endtask

    task automatic test_register_settings();
        for (int k = 0; k < 6; k++)
        begin
            case (k)
                0:       apply_config(8'h00, 1'b1, 4'd0);
                1:       apply_config(8'hFF, 1'b1, 4'd8);
                2:       apply_config(8'h5A, 1'b0, 4'd15);
                3:       apply_config(8'($urandom), 1'b1, 4'd9);
                4:       apply_config(8'hA5, 1'b0, 4'd1);
                default: apply_config(8'($urandom), 1'($urandom), 4'($urandom));
            endcase
            send_req(put_item(CHAR_TAB, 1'b1));
            send_req(put_item(CHAR_TAB, 1'b0));
            repeat (12)
                send_req(random_item(12));
        end
    endtask

    task automatic test_wrap_and_scroll();
        apply_config(8'h3C, 1'b0, 4'd8);
        while (crow != ROWS - 1)
            send_req(put_item(CHAR_NL, 1'($urandom)));
        repeat (9)
            send_req(put_item(CHAR_TAB, 1'b0));
        repeat (4)
            send_req(put_item(printable(), 1'($urandom)));
        // this tab crosses the last column of the bottom row and scrolls midway
        send_req(put_item(CHAR_TAB, 1'b0));
        repeat (3)
            send_req(read_item(11'((ROWS - 2) * COLS + $urandom_range(COLS - 1))));
        repeat (2)
            send_req(read_item(11'((ROWS - 1) * COLS + $urandom_range(COLS - 1))));
        while (ccol < COLS - 1)
            send_req(put_item((ccol + 8 < COLS) ? CHAR_TAB : printable(), 1'b0));
        send_req(put_item(printable(), 1'b0));
        send_req(put_item(CHAR_BS, 1'b0));
        send_req(put_item(CHAR_NL, 1'b1));
        send_req(read_item(11'((ROWS - 2) * COLS + COLS - 1)));
        send_req(read_item(11'((ROWS - 1) * COLS)));
    endtask

    task automatic test_clear_screen();
        apply_config(8'h1E, 1'b1, 4'd3);
        send_req(other_item(REQ_CLEAR));
        send_req(read_item(11'd0));
        send_req(read_item(11'(CELLS - 1)));
        send_req(read_item(11'h7FF));
        repeat (3)
            send_req(put_item(printable(), 1'b0));
        send_req(put_item(CHAR_BS, 1'b0));
        send_req(read_item(11'd2));
        send_req(other_item(REQ_CLEAR));
        send_req(read_item(11'd1));
    endtask

    task automatic test_random_mix();
        for (int n = 0; n < 70; n++)
        begin
            if (n % 20 == 0)
                apply_config(8'($urandom), 1'($urandom), 4'($urandom));
            idle_pct = (n >= 20 && n < 50) ? 0 : 33;
            if (n == 35 || $urandom_range(24) == 0)
                wait_results_done();
            send_req(random_item(18));
        end
        idle_pct = 33;
    endtask

    initial
    begin
        for (int i = 0; i < CELLS; i++)
            shadow_cells[i] = RESET_CELL;
        crow            = 0;
        ccol            = 0;
        cfg.text_attr   = RESET_CELL[15:8];
        cfg.serial_echo = 1'b0;
        cfg.tab_width   = TAB_WIDTH_RESET;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_reset_contents();
        test_put_basics();
        test_register_settings();
        test_wrap_and_scroll();
        test_clear_screen();
        test_random_mix();

        wait_results_done();
        repeat (DRAIN_PAUSE) @(posedge clk);

        $display("Run: %0d requests, %0d result transactions, %0d scrolls, %0d clears",
                 items_sent, results_seen, scrolls, clears);
        $display("Register settings applied: %0d; mismatches: %0d", settings, errors);
        if (errors == 0 && expected_rsps.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
